// File: rtl/tt_pkg.sv
// ----------------------------------------------------------------------------
// tt_pkg
// shared widths, payload types and controller/datapath signal groups
// ----------------------------------------------------------------------------
package tt_pkg;

    localparam int POS_W   = 32;
    localparam int UV_W    = 16;
    localparam int UV_FRAC = 12;
    localparam int PD_W    = POS_W + 1;
    localparam int UD_W    = UV_W + 1;
    localparam int PROD_W  = PD_W + UD_W;
    localparam int NUM_W   = PROD_W + 1;
    localparam int DPR_W   = 2 * UD_W;
    localparam int DET_W   = DPR_W + 1;
    localparam int DIVD_W  = NUM_W + UV_FRAC;
    localparam int ITER_W  = $clog2(POS_W);
    localparam int NCOMP   = 3;
    localparam int COMP_W  = 2;
    localparam int NCOPY   = 3;
    localparam int COPY_W  = 2;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [UV_W-1:0]  tex_u;
        logic signed [UV_W-1:0]  tex_v;
    } vtx_t;

    typedef struct packed {
        logic signed [POS_W-1:0] tan_x;
        logic signed [POS_W-1:0] tan_y;
        logic signed [POS_W-1:0] tan_z;
        logic                    degenerate;
        logic                    saturated;
        logic                    last;
    } res_t;

    typedef struct packed {
        logic              load_corner;
        logic              corner_slot;
        logic              load_tri;
        logic              det_mul;
        logic              det_sub;
        logic              prod;
        logic              div_load;
        logic              div_step;
        logic              fin;
        logic              publish;
        logic [COMP_W-1:0] comp;
    } cmd_t;

    typedef struct packed {
        logic det_zero;
    } sts_t;

endpackage

// File: rtl/tt_datapath.sv
// ----------------------------------------------------------------------------
// tt_datapath
// corner store, edge and uv deltas, products, restoring divider, saturation
// ----------------------------------------------------------------------------
module tt_datapath
    import tt_pkg::*;
(
    input  logic clk,
    input  cmd_t cmd,
    input  vtx_t vtx,
    output sts_t sts,
    output res_t res
);

    logic signed [POS_W-1:0]  cx_reg [2];
    logic signed [POS_W-1:0]  cy_reg [2];
    logic signed [POS_W-1:0]  cz_reg [2];
    logic signed [UV_W-1:0]   cu_reg [2];
    logic signed [UV_W-1:0]   cv_reg [2];
    logic signed [PD_W-1:0]   e1_reg [NCOMP];
    logic signed [PD_W-1:0]   e2_reg [NCOMP];
    logic signed [UD_W-1:0]   du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [DPR_W-1:0]  dpa_reg, dpb_reg;
    logic signed [DET_W-1:0]  det_w;
    logic [DET_W-1:0]         dmag_reg;
    logic                     dneg_reg, dzero_reg;
    logic signed [PROD_W-1:0] pa_reg, pb_reg;
    logic signed [NUM_W-1:0]  num_w;
    logic [NUM_W-1:0]         nmag_w;
    logic [DIVD_W-1:0]        dvd_w;
    logic                     nneg_reg, big_reg;
    logic [DET_W-1:0]         rem_reg;
    logic [POS_W-1:0]         qr_reg;
    logic [DET_W:0]           r2_w;
    logic                     ge_w;
    logic [DET_W-1:0]         rsub_w;
    logic [POS_W-1:0]         tan_reg [NCOMP];
    logic [POS_W-1:0]         tval_w;
    logic                     tsat_w, neg_w;
    logic                     sat_reg;
    res_t                     res_reg;

    localparam logic [POS_W-1:0] LIM_NEG = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [POS_W-1:0] LIM_POS = {1'b0, {(POS_W-1){1'b1}}};

    assign det_w  = DET_W'(dpa_reg) - DET_W'(dpb_reg);
    assign num_w  = NUM_W'(pa_reg) - NUM_W'(pb_reg);
    assign nmag_w = num_w[NUM_W-1] ? NUM_W'(-num_w) : NUM_W'(num_w);
    assign dvd_w  = {nmag_w, {UV_FRAC{1'b0}}};
    assign r2_w   = {rem_reg, qr_reg[POS_W-1]};
    assign ge_w   = r2_w >= {1'b0, dmag_reg};
    assign rsub_w = DET_W'(r2_w - {1'b0, dmag_reg});
    assign neg_w  = nneg_reg ^ dneg_reg;

    always_comb
    begin
        if (neg_w)
        begin
            tsat_w = big_reg || (qr_reg > LIM_NEG);
            tval_w = tsat_w ? LIM_NEG : POS_W'(-qr_reg);
        end
        else
        begin
            tsat_w = big_reg || qr_reg[POS_W-1];
            tval_w = tsat_w ? LIM_POS : qr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_corner)
        begin
            cx_reg[cmd.corner_slot] <= vtx.pos_x;
            cy_reg[cmd.corner_slot] <= vtx.pos_y;
            cz_reg[cmd.corner_slot] <= vtx.pos_z;
            cu_reg[cmd.corner_slot] <= vtx.tex_u;
            cv_reg[cmd.corner_slot] <= vtx.tex_v;
        end
        if (cmd.load_tri)
        begin
            e1_reg[0] <= PD_W'(vtx.pos_x) - PD_W'(cx_reg[0]);
            e1_reg[1] <= PD_W'(vtx.pos_y) - PD_W'(cy_reg[0]);
            e1_reg[2] <= PD_W'(vtx.pos_z) - PD_W'(cz_reg[0]);
            e2_reg[0] <= PD_W'(cx_reg[1]) - PD_W'(cx_reg[0]);
            e2_reg[1] <= PD_W'(cy_reg[1]) - PD_W'(cy_reg[0]);
            e2_reg[2] <= PD_W'(cz_reg[1]) - PD_W'(cz_reg[0]);
            du1_reg   <= UD_W'(vtx.tex_u) - UD_W'(cu_reg[0]);
            dv1_reg   <= UD_W'(vtx.tex_v) - UD_W'(cv_reg[0]);
            du2_reg   <= UD_W'(cu_reg[1]) - UD_W'(cu_reg[0]);
            dv2_reg   <= UD_W'(cv_reg[1]) - UD_W'(cv_reg[0]);
            for (int k = 0; k < NCOMP; k++)
            begin
                tan_reg[k] <= '0;
            end
            sat_reg <= 1'b0;
        end
        if (cmd.det_mul)
        begin
            dpa_reg <= du1_reg * dv2_reg;
            dpb_reg <= dv1_reg * du2_reg;
        end
        if (cmd.det_sub)
        begin
            dmag_reg  <= det_w[DET_W-1] ? DET_W'(-det_w) : DET_W'(det_w);
            dneg_reg  <= det_w[DET_W-1];
            dzero_reg <= (det_w == '0);
        end
        if (cmd.prod)
        begin
            pa_reg <= e1_reg[cmd.comp] * dv2_reg;
            pb_reg <= e2_reg[cmd.comp] * dv1_reg;
        end
        if (cmd.div_load)
        begin
            nneg_reg <= num_w[NUM_W-1];
            big_reg  <= {{(DET_W+POS_W-DIVD_W){1'b0}}, dvd_w} >= {dmag_reg, {POS_W{1'b0}}};
            rem_reg  <= DET_W'(dvd_w[DIVD_W-1:POS_W]);
            qr_reg   <= dvd_w[POS_W-1:0];
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge_w ? rsub_w : r2_w[DET_W-1:0];
            qr_reg  <= {qr_reg[POS_W-2:0], ge_w};
        end
        if (cmd.fin)
        begin
            tan_reg[cmd.comp] <= tval_w;
            sat_reg           <= sat_reg | tsat_w;
        end
        if (cmd.publish)
        begin
            res_reg.tan_x      <= tan_reg[0];
            res_reg.tan_y      <= tan_reg[1];
            res_reg.tan_z      <= tan_reg[2];
            res_reg.degenerate <= dzero_reg;
            res_reg.saturated  <= sat_reg;
            res_reg.last       <= 1'b0;
        end
    end

    assign sts.det_zero = dzero_reg;
    assign res          = res_reg;

endmodule

// File: rtl/tt_ctrl.sv
// ----------------------------------------------------------------------------
// tt_ctrl
// sequencer for corner capture, per-component divide and result copies
// ----------------------------------------------------------------------------
module tt_ctrl
    import tt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic vtx_valid,
    output logic vtx_ready,
    output logic res_valid,
    input  logic res_ready,
    output logic res_last,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DMUL = 9'b000000010,
        S_DSUB = 9'b000000100,
        S_CHK  = 9'b000001000,
        S_MUL  = 9'b000010000,
        S_LOAD = 9'b000100000,
        S_DIV  = 9'b001000000,
        S_FIN  = 9'b010000000,
        S_PUB  = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          corner_reg, corner_next;
    logic [COMP_W-1:0]   comp_reg, comp_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [COPY_W-1:0]   copy_reg, copy_next;
    logic                acc;

    assign vtx_ready = (state_reg == S_IDLE);
    assign acc       = vtx_valid && vtx_ready;
    assign res_valid = (copy_reg != '0);
    assign res_last  = (copy_reg == COPY_W'(1));

    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        comp_next   = comp_reg;
        iter_next   = iter_reg;
        copy_next   = copy_reg;
        cmd         = '0;
        cmd.comp    = comp_reg;
        if (res_valid && res_ready)
        begin
            copy_next = copy_reg - COPY_W'(1);
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (corner_reg == 2'd2)
                    begin
                        cmd.load_tri = 1'b1;
                        corner_next  = 2'd0;
                        state_next   = S_DMUL;
                    end
                    else
                    begin
                        cmd.load_corner = 1'b1;
                        cmd.corner_slot = (corner_reg == 2'd1);
                        corner_next     = (corner_reg == 2'd1) ? 2'd2 : 2'd1;
                    end
                end
            end
            S_DMUL:
            begin
                cmd.det_mul = 1'b1;
                state_next  = S_DSUB;
            end
            S_DSUB:
            begin
                cmd.det_sub = 1'b1;
                state_next  = S_CHK;
            end
            S_CHK:
            begin
                comp_next  = '0;
                state_next = sts.det_zero ? S_PUB : S_MUL;
            end
            S_MUL:
            begin
                cmd.prod   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.div_load = 1'b1;
                iter_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(POS_W - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.fin = 1'b1;
                if (comp_reg == COMP_W'(NCOMP - 1))
                begin
                    state_next = S_PUB;
                end
                else
                begin
                    comp_next  = comp_reg + COMP_W'(1);
                    state_next = S_MUL;
                end
            end
            S_PUB:
            begin
                if (copy_reg == '0)
                begin
                    cmd.publish = 1'b1;
                    copy_next   = COPY_W'(NCOPY);
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            corner_reg <= '0;
            comp_reg   <= '0;
            iter_reg   <= '0;
            copy_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
            comp_reg   <= comp_next;
            iter_reg   <= iter_next;
            copy_reg   <= copy_next;
        end
    end

endmodule

// File: rtl/triangle_tangent_vector.sv
// sequence: the third vertex of a triangle starts the determinant, then each of the three
// components takes a product step, a divider load, a 32-step divider and a finish step
// (components skipped for a zero determinant); a new vertex is accepted only in idle
// corner vertices are captured without leaving idle; results wait in an output register
// reset: asynchronous active low, clears the sequencer, corner count and copy count
// ----------------------------------------------------------------------------
// triangle_tangent_vector
// per-triangle tangent from position and uv deltas, three copies per triangle
// ----------------------------------------------------------------------------
module triangle_tangent_vector
    import tt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic vtx_valid,
    output logic vtx_ready,
    input  vtx_t vtx_data,
    output logic res_valid,
    input  logic res_ready,
    output res_t res_data
);

    cmd_t cmd;
    sts_t sts;
    res_t held;
    logic last;

    tt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_last  (last),
        .sts       (sts),
        .cmd       (cmd)
    );

    tt_datapath u_dp (
        .clk   (clk),
        .cmd   (cmd),
        .vtx   (vtx_data),
        .sts   (sts),
        .res   (held)
    );

    always_comb
    begin
        res_data      = held;
        res_data.last = last;
    end

endmodule

// File: rtl/tt_checker.sv
// ----------------------------------------------------------------------------
// tt_checker
// port-level checks on result hold, degenerate results, repeated copies and the last copy
// ----------------------------------------------------------------------------
module tt_checker
    import tt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic vtx_valid,
    input logic vtx_ready,
    input logic res_valid,
    input logic res_ready,
    input res_t res_data
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.degenerate |-> res_data.tan_x == '0 &&
        res_data.tan_y == '0 && res_data.tan_z == '0 && !res_data.saturated)
        else $error("degenerate result not zero");

    a_copy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_data.last |=> res_valid &&
        res_data.tan_x == $past(res_data.tan_x) &&
        res_data.tan_y == $past(res_data.tan_y) &&
        res_data.tan_z == $past(res_data.tan_z))
        else $error("copies of a triangle differ");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && res_data.last |=> !res_valid)
        else $error("result after last copy");

endmodule

bind triangle_tangent_vector tt_checker u_tt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);

// File: test/tb_triangle_tangent_vector.sv
// ----------------------------------------------------------------------------
// tb_triangle_tangent_vector
// streams vertices into the tangent block and checks every tangent copy
// against an in-bench fixed-point predictor, with random idling on both sides
// ----------------------------------------------------------------------------
module tb_triangle_tangent_vector;

    timeunit 1ns;
    timeprecision 1ps;

    import tt_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 250;
    localparam int NUM_RANDOM_TRI = 70;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic vtx_valid = 1'b0;
    logic vtx_ready;
    vtx_t vtx_data = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res_data;

    vtx_t pend_q[$];
    bit   hold_q[$];
    res_t tangent_q[$];

    logic signed [POS_W-1:0] held_px[2], held_py[2], held_pz[2];
    logic signed [UV_W-1:0]  held_u[2], held_v[2];
    int   held_count = 0;

    int   errors = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   sent = 0;
    int   quiet_cycles = 0;

    triangle_tangent_vector u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .vtx_data  (vtx_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    always #5 clk = ~clk;

    function automatic logic signed [POS_W-1:0] tangent_comp(
        input logic signed [127:0] num, input logic signed [127:0] det, inout bit sat);
        logic signed [127:0] q;
        q = (num * 128'sd4096) / det;
        if (q > 128'sd2147483647)
        begin
            sat = 1'b1;
            q = 128'sd2147483647;
        end
        else if (q < -128'sd2147483648)
        begin
            sat = 1'b1;
            q = -128'sd2147483648;
        end
        return q[POS_W-1:0];
    endfunction

    task automatic predict_tangent(input vtx_t v);
        logic signed [127:0] e1[3], e2[3], du1, dv1, du2, dv2, det;
        logic signed [POS_W-1:0] t[3];
        bit sat, degen;
        res_t r;
        int slot;
        if (held_count != 2)
        begin
            slot = (held_count == 1) ? 1 : 0;
            held_px[slot] = v.pos_x;
            held_py[slot] = v.pos_y;
            held_pz[slot] = v.pos_z;
            held_u[slot]  = v.tex_u;
            held_v[slot]  = v.tex_v;
            held_count = slot + 1;
            return;
        end
        held_count = 0;
        e1[0] = 128'(v.pos_x) - 128'(held_px[0]);
        e1[1] = 128'(v.pos_y) - 128'(held_py[0]);
        e1[2] = 128'(v.pos_z) - 128'(held_pz[0]);
        e2[0] = 128'(held_px[1]) - 128'(held_px[0]);
        e2[1] = 128'(held_py[1]) - 128'(held_py[0]);
        e2[2] = 128'(held_pz[1]) - 128'(held_pz[0]);
        du1 = 128'(v.tex_u) - 128'(held_u[0]);
        dv1 = 128'(v.tex_v) - 128'(held_v[0]);
        du2 = 128'(held_u[1]) - 128'(held_u[0]);
        dv2 = 128'(held_v[1]) - 128'(held_v[0]);
        det = du1 * dv2 - dv1 * du2;
        degen = (det == 0);
        sat = 1'b0;
        for (int j = 0; j < 3; j++)
            t[j] = degen ? '0 : tangent_comp(e1[j] * dv2 - e2[j] * dv1, det, sat);
        for (int k = 0; k < 3; k++)
        begin
            r.tan_x = t[0];
            r.tan_y = t[1];
            r.tan_z = t[2];
            r.degenerate = degen;
            r.saturated = sat;
            r.last = (k == 2);
            tangent_q.push_back(r);
        end
    endtask

    task automatic add_vtx(input int px, input int py, input int pz,
                           input int u, input int v, input bit hold);
        vtx_t x;
        x.pos_x = px;
        x.pos_y = py;
        x.pos_z = pz;
        x.tex_u = u[UV_W-1:0];
        x.tex_v = v[UV_W-1:0];
        pend_q.push_back(x);
        hold_q.push_back(hold);
    endtask

    function automatic int rand_pos(input int kind);
        case (kind)
            0: return int'($urandom);
            1: return int'($urandom_range(0, 2097151)) - 1048576;
            default: return int'($urandom_range(0, 131071)) - 65536;
        endcase
    endfunction

    function automatic int rand_uv(input int kind);
        if (kind == 0)
            return int'($urandom_range(0, 65535)) - 32768;
        return int'($urandom_range(0, 8191)) - 4096;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (vtx_valid && vtx_ready)
            begin
                predict_tangent(vtx_data);
                sent <= sent + 1;
            end
            if (!vtx_valid || vtx_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    vtx_valid <= 1'b0;
                end
                else if (pend_q.size() > 0 && !(hold_q[0] && tangent_q.size() > 0))
                begin
                    vtx_data <= pend_q.pop_front();
                    void'(hold_q.pop_front());
                    vtx_valid <= 1'b1;
                    send_gap <= (sent > 90 && sent < 130) ? 0 : $urandom_range(0, 19);
                end
                else
                    vtx_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_r;
        int   gap;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (tangent_q.size() == 0)
                begin
                    $error("result with nothing expected: %p", res_data);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_r = tangent_q.pop_front();
                    if (res_data.tan_x !== exp_r.tan_x)
                        $error("tan_x expected %0d actual %0d", exp_r.tan_x, res_data.tan_x);
                    if (res_data.tan_y !== exp_r.tan_y)
                        $error("tan_y expected %0d actual %0d", exp_r.tan_y, res_data.tan_y);
                    if (res_data.tan_z !== exp_r.tan_z)
                        $error("tan_z expected %0d actual %0d", exp_r.tan_z, res_data.tan_z);
                    if (res_data.degenerate !== exp_r.degenerate)
                        $error("degenerate expected %0b actual %0b",
                               exp_r.degenerate, res_data.degenerate);
                    if (res_data.saturated !== exp_r.saturated)
                        $error("saturated expected %0b actual %0b",
                               exp_r.saturated, res_data.saturated);
                    if (res_data.last !== exp_r.last)
                        $error("last expected %0b actual %0b", exp_r.last, res_data.last);
                    if (res_data !== exp_r)
                        errors <= errors + 1;
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                res_ready <= (recv_gap == 1);
            end
            else if (res_valid && res_ready)
            begin
                gap = (sent > 90 && sent < 130) ? 0 : $urandom_range(0, 19);
                recv_gap <= gap;
                res_ready <= (gap == 0);
            end
            else
                res_ready <= 1'b1;
        end
    end

    // watchdog on accepted traffic
    always @(posedge clk)
    begin
        if ((vtx_valid && vtx_ready) || (res_valid && res_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int kind, ukind, u1, v1, u2, v2;
        // directed triangles (simple, extremes, degenerate and saturating), then random ones
        add_vtx(0, 0, 0, 0, 0, 1'b0);
        add_vtx(65536, 0, 0, 4096, 0, 1'b0);
        add_vtx(0, 65536, 0, 0, 4096, 1'b0);
        add_vtx(-2147483648, -2147483648, -2147483648, -32768, -32768, 1'b1);
        add_vtx(2147483647, 2147483647, 2147483647, 32767, 32767, 1'b0);
        add_vtx(2147483647, -2147483648, 0, -32768, 32767, 1'b0);
        add_vtx(100, 200, 300, 5, 5, 1'b0);
        add_vtx(400, 500, 600, 5, 5, 1'b0);
        add_vtx(700, 800, 900, 5, 5, 1'b0);
        add_vtx(-2147483648, 2147483647, -2147483648, 0, 0, 1'b0);
        add_vtx(2147483647, -2147483648, 2147483647, 1, 0, 1'b0);
        add_vtx(2147483647, 2147483647, -2147483648, 0, 1, 1'b0);
        add_vtx(2147483647, -2147483648, 2147483647, 32767, -32768, 1'b1);
        add_vtx(-2147483648, 2147483647, -2147483648, -32768, 32767, 1'b0);
        add_vtx(0, 0, 0, 32767, 32767, 1'b0);
        add_vtx(-65536, 131072, 12345, -100, 300, 1'b0);
        add_vtx(65536, -131072, -54321, 250, -80, 1'b0);
        add_vtx(1, -1, 7, 900, 700, 1'b0);
        for (int t = 0; t < NUM_RANDOM_TRI; t++)
        begin
            kind = $urandom_range(0, 3);
            ukind = $urandom_range(0, 1);
            u1 = rand_uv(ukind);
            v1 = rand_uv(ukind);
            u2 = rand_uv(ukind);
            v2 = rand_uv(ukind);
            add_vtx(rand_pos(kind), rand_pos(kind), rand_pos(kind), u1, v1,
                    $urandom_range(0, 15) == 0);
            add_vtx(rand_pos(kind), rand_pos(kind), rand_pos(kind), u2, v2, 1'b0);
            if (kind == 3)
                add_vtx(rand_pos(kind), rand_pos(kind), rand_pos(kind), u1, v1, 1'b0);
            else
                add_vtx(rand_pos(kind), rand_pos(kind), rand_pos(kind),
                        rand_uv(ukind), rand_uv(ukind), 1'b0);
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait (pend_q.size() == 0 && !vtx_valid && tangent_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && tangent_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
rtl/tt_pkg.sv
rtl/tt_datapath.sv
rtl/tt_ctrl.sv
rtl/triangle_tangent_vector.sv
rtl/tt_checker.sv
test/tb_triangle_tangent_vector.sv
